// ===== src/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int ValueW = 8;
    localparam int PrioW  = 16;
    localparam int CountW = 5;

    localparam logic [ValueW-1:0] EMPTY_MARK = 8'd120;
    localparam logic [CountW-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic
    {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [ValueW-1:0]       value;
        logic signed [PrioW-1:0] prio;
    } entry_t;

    // Per-cell control from the queue controller.
    typedef struct packed
    {
        logic enq;        // enqueue accepted this cycle
        logic deq;        // dequeue accepted this cycle
        logic occupied;   // cell index below the fill count
        logic left_keep;  // left neighbour holds (always set for the head cell)
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/spq_if.sv =====
`default_nettype none

interface spq_req_if;
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic [spq_pkg::ValueW-1:0]         item_value;
    logic signed [spq_pkg::PrioW-1:0]   item_priority;

    modport source (output valid, opcode, item_value, item_priority, input ready);
    modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface spq_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [spq_pkg::ValueW-1:0]     out_value;
    logic [spq_pkg::CountW-1:0]     fill_count;

    modport source (output valid, status, out_value, fill_count, input ready);
    modport sink   (input valid, status, out_value, fill_count, output ready);
endinterface

`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none

module spq_cell
(
    input  wire logic                clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t     new_entry,
    input  wire spq_pkg::entry_t     left_entry,
    input  wire spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t          entry,
    output logic                     keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Hold when occupied and not of lower priority than the newcomer.
    assign keep  = ctrl.occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && !keep)
        begin
            entry_next = ctrl.left_keep ? new_entry : left_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
`default_nettype none

// Channel   | Modport | Payload                                  | Role
// ----------+---------+------------------------------------------+------------------------
// request   | sink    | opcode, item_value, item_priority        | enqueue / dequeue
// result    | source  | status, out_value, fill_count            | one per request
// cfg_we/.. | plain   | cfg_wdata[4:0]                           | capacity register
//
// One request is taken per cycle while the result register is empty or being drained;
// its result appears in the result register on the next cycle. The row of cells
// compares every entry with the incoming priority at once and shifts as the request is taken.
// A request is taken whenever the result register is empty or being drained.
// Reset clears the fill count, the result valid and sets capacity to 16; cell
// contents are left as they are and only read below the fill count.

module sorted_priority_queue
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    spq_req_if.sink                         request,
    spq_res_if.source                       result,
    input  wire logic                       cfg_we,
    input  wire logic [spq_pkg::CountW-1:0] cfg_wdata
);

    // Width wide enough for both the fill count and DEPTH.
    localparam int DepthW = $clog2(DEPTH + 1);
    localparam int CmpW   = (DepthW > spq_pkg::CountW) ? DepthW : spq_pkg::CountW;

    logic [spq_pkg::CountW-1:0] capacity_reg;
    logic [spq_pkg::CountW-1:0] count_reg;
    logic [spq_pkg::CountW-1:0] count_next;

    logic                       res_valid_reg;
    spq_pkg::status_t           res_status_reg;
    spq_pkg::status_t           res_status_next;
    logic [spq_pkg::ValueW-1:0] res_value_reg;
    logic [spq_pkg::ValueW-1:0] res_value_next;
    logic [spq_pkg::CountW-1:0] res_fill_reg;

    logic            req_fire;
    logic            is_deq;
    logic            full;
    logic            empty;
    logic            do_enq;
    logic            do_deq;
    spq_pkg::entry_t new_entry;

    spq_pkg::entry_t cell_entry [DEPTH];
    logic            cell_keep  [DEPTH];

    // Take a request whenever the result register is free or emptying.
    assign request.ready = !res_valid_reg || result.ready;
    assign req_fire      = request.valid && request.ready;
    assign is_deq        = (request.opcode == spq_pkg::OP_DEQ);

    // Limit is the lower of capacity and the built depth.
    assign full  = (CmpW'(count_reg) >= CmpW'(DEPTH)) || (count_reg >= capacity_reg);
    assign empty = (count_reg == '0);

    assign do_enq = req_fire && !is_deq && !full;
    assign do_deq = req_fire && is_deq && !empty;

    assign new_entry.value = request.item_value;
    assign new_entry.prio  = request.item_priority;

    // Row of cells: head at index 0, each fed by the neighbours it has.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::cell_ctrl_t ctrl;
        spq_pkg::entry_t     left_entry;
        spq_pkg::entry_t     right_entry;

        assign ctrl.enq      = do_enq;
        assign ctrl.deq      = do_deq;
        assign ctrl.occupied = (CmpW'(i) < CmpW'(count_reg));

        if (i == 0)
        begin : g_head
            assign ctrl.left_keep = 1'b1;
            assign left_entry     = new_entry;
        end
        else
        begin : g_body
            assign ctrl.left_keep = cell_keep[i-1];
            assign left_entry     = cell_entry[i-1];
        end

        // Tail holds its own contents on a dequeue.
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // Fill count and result contents for the request being taken.
    always_comb
    begin
        count_next      = count_reg;
        res_status_next = spq_pkg::ST_OK;
        res_value_next  = '0;
        if (is_deq)
        begin
            if (empty)
            begin
                res_status_next = spq_pkg::ST_EMPTY;
                res_value_next  = spq_pkg::EMPTY_MARK;
            end
            else
            begin
                res_value_next = cell_entry[0].value;
                count_next     = count_reg - spq_pkg::CountW'(1);
            end
        end
        else
        begin
            if (full)
            begin
                res_status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + spq_pkg::CountW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= spq_pkg::CAPACITY_RESET;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (req_fire)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on each taken request, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_fill_reg   <= count_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.status     = res_status_reg;
    assign result.out_value  = res_value_reg;
    assign result.fill_count = res_fill_reg;

endmodule

`default_nettype wire

// ===== tb/sv/spq_result_checker.sv =====
`timescale 1ns / 1ps

module spq_result_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    spq_req_if                     request,
    spq_res_if                     result,
    input  wire logic              cfg_we,
    input  wire logic [CountW-1:0] cfg_wdata,
    output int                     fail_count,
    output int                     expected_left
);

    typedef struct packed
    {
        status_t           status;
        logic [ValueW-1:0] value;
        logic [CountW-1:0] fill;
    } queue_result_t;

    // Shadow of the queue contents, front entry at index 0.
    logic [ValueW-1:0]       held_value [DEPTH];
    logic signed [PrioW-1:0] held_prio  [DEPTH];
    int                      held_count = 0;
    logic [CountW-1:0]       capacity   = CAPACITY_RESET;
    queue_result_t           awaited_results [$];
    int                      mismatches = 0;

    function automatic queue_result_t apply_request(
        input opcode_t                 op,
        input logic [ValueW-1:0]       value,
        input logic signed [PrioW-1:0] prio
    );
        queue_result_t res;
        int            limit;
        int            slot;
        int            j;
        res.status = ST_OK;
        res.value  = '0;
        limit = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
        if (op == OP_ENQ)
        begin
            if (held_count >= limit)
                res.status = ST_FULL;
            else
            begin
                // go in behind every entry of equal or higher priority
                slot = 0;
                while (slot < held_count && held_prio[slot] >= prio)
                    slot++;
                for (j = held_count; j > slot; j--)
                begin
                    held_value[j] = held_value[j-1];
                    held_prio[j]  = held_prio[j-1];
                end
                held_value[slot] = value;
                held_prio[slot]  = prio;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            res.status = ST_EMPTY;
            res.value  = EMPTY_MARK;
        end
        else
        begin
            res.value = held_value[0];
            for (j = 0; j + 1 < held_count; j++)
            begin
                held_value[j] = held_value[j+1];
                held_prio[j]  = held_prio[j+1];
            end
            held_count--;
        end
        res.fill = CountW'(held_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            held_count = 0;
            capacity   = CAPACITY_RESET;
            awaited_results.delete();
            expected_left <= 0;
        end
        else
        begin
            // compare first: a result never belongs to a request taken at the same edge
            if (result.valid && result.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with no request waiting: status %0d value %0d fill %0d",
                                 $realtime, result.status, result.out_value, result.fill_count);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status != want.status || result.out_value != want.value ||
                        result.fill_count != want.fill)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch: expected status %0d value %0d fill %0d, got status %0d value %0d fill %0d",
                                     $realtime, want.status, want.value, want.fill,
                                     result.status, result.out_value, result.fill_count);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                capacity = cfg_wdata;
            if (request.valid && request.ready)
                awaited_results.push_back(apply_request(opcode_t'(request.opcode),
                                                        request.item_value,
                                                        request.item_priority));
            expected_left <= awaited_results.size();
        end
    end

    assign fail_count = mismatches;

endmodule

// ===== tb/sv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HOLD_CYCLES = 200;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CountW-1:0] cfg_wdata;
    int                fail_count;
    int                expected_left;

    // Chance in a hundred that either side idles at each draw; zero for a steady stretch.
    int   idle_pct = 17;
    // Raised by the stimulus to make the receiver hold off; dropped by the receiver.
    logic hold_results = 1'b0;

    spq_req_if request();
    spq_res_if result();

    sorted_priority_queue #(.DEPTH(DEPTH)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    spq_result_checker #(.DEPTH(DEPTH)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the queue locks up and results never arrive.
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: drop ready at random, and hold it low for a long stretch on demand.
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result.ready <= 1'b0;
                // count the stall here so the sender keeps pushing meanwhile
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Offer one request, idling beforehand at random, and hold it until taken.
    task automatic offer_request(
        input opcode_t                 op,
        input logic [ValueW-1:0]       value,
        input logic signed [PrioW-1:0] prio
    );
        while ($urandom_range(99) < idle_pct)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid         <= 1'b1;
        request.opcode        <= op;
        request.item_value    <= value;
        request.item_priority <= prio;
        do
            @(posedge clk);
        while (!request.ready);
    endtask

    // Stop sending, wait until every result is back, then write the capacity.
    task automatic set_capacity(input logic [CountW-1:0] cap);
        request.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        // let the result register settle before touching the register
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random requests; enq_pct sets the mix of enqueues against dequeues.
    task automatic run_burst(input int count, input int enq_pct);
        opcode_t                 op;
        logic [ValueW-1:0]       value;
        logic signed [PrioW-1:0] prio;
        int                      pick;
        for (int i = 0; i < count; i++)
        begin
            op    = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
            value = ValueW'($urandom);
            // mix a narrow band (plenty of ties), the extremes and anything at all
            case ($urandom_range(2))
                0:
                begin
                    pick = int'($urandom_range(8)) - 4;
                    prio = PrioW'(pick);
                end
                1:
                begin
                    case ($urandom_range(3))
                        0:       prio = 16'sh8000;
                        1:       prio = 16'sh7FFF;
                        2:       prio = -16'sd1;
                        default: prio = 16'sd0;
                    endcase
                end
                default: prio = PrioW'($urandom);
            endcase
            offer_request(op, value, prio);
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        request.valid         = 1'b0;
        request.opcode        = OP_ENQ;
        request.item_value    = '0;
        request.item_priority = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, priority extremes, ties kept in arrival order.
        offer_request(OP_DEQ, 8'h00, 16'sh0000);
        offer_request(OP_ENQ, 8'h00, 16'sh8000);
        offer_request(OP_ENQ, 8'hFF, 16'sh7FFF);
        offer_request(OP_ENQ, 8'hA5, 16'sh0000);
        offer_request(OP_ENQ, 8'h5A, 16'sh0000);
        offer_request(OP_ENQ, 8'h3C, -16'sd1);
        offer_request(OP_ENQ, 8'hC3, 16'sh7FFF);
        repeat (7) offer_request(OP_DEQ, 8'hFF, 16'shFFFF);

        // Zero capacity: enqueue refused as full, dequeue sees empty.
        set_capacity(5'd0);
        offer_request(OP_ENQ, 8'h77, 16'sh1234);
        offer_request(OP_DEQ, 8'h00, 16'sh0000);

        // Capacity above the built depth saturates; lean on enqueues to hit it.
        set_capacity(5'd31);
        run_burst(200, 70);

        set_capacity(5'd1);
        run_burst(100, 50);

        set_capacity(5'd5);
        run_burst(150, 60);

        // Long stretch with no idling on either side.
        set_capacity(5'd16);
        idle_pct = 0;
        run_burst(250, 50);
        idle_pct = 17;

        // Receiver holds off while requests keep coming, so the input stalls.
        hold_results = 1'b1;
        run_burst(60, 60);

        // Fill up, then lower the capacity below the fill; held entries must stay.
        run_burst(30, 95);
        set_capacity(5'd3);
        run_burst(100, 45);

        set_capacity(5'd0);
        run_burst(40, 50);

        set_capacity(5'd8);
        run_burst(250, 55);

        set_capacity(5'd16);
        run_burst(300, 50);

        // Drain, wait for stray results, then give the verdict.
        request.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_left != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_if.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/sv/spq_result_checker.sv
tb/sv/sorted_priority_queue_tb.sv
